// File: hw/rtl/lclp_pkg.sv
package lclp_pkg;

   localparam int LINE_MAX = 32;
   localparam int LEN_W = $clog2(LINE_MAX + 1);
   localparam int HEAD_BYTES = 8;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO = "0";
   localparam logic [7:0] CHAR_FIVE = "5";
   localparam logic [7:0] CHAR_NINE = "9";
   localparam logic [8:0] BYTE_MAX = 9'd255;

   // event codes
   localparam logic [3:0] EV_SET_LED = 4'd0;
   localparam logic [3:0] EV_SET_ALL = 4'd1;
   localparam logic [3:0] EV_ANIM = 4'd2;
   localparam logic [3:0] EV_HBT = 4'd3;
   localparam logic [3:0] EV_RESET = 4'd4;
   localparam logic [3:0] EV_STATUS = 4'd5;
   localparam logic [3:0] EV_GRAMMAR = 4'd6;
   localparam logic [3:0] EV_RANGE = 4'd7;
   localparam logic [3:0] EV_OVERFLOW = 4'd8;

   // keyword numbers match the event codes of their commands
   localparam int NUM_KW = 6;
   localparam logic [2:0] KW_SET_LED = 3'd0;
   localparam logic [2:0] KW_SET_ALL = 3'd1;
   localparam logic [2:0] KW_ANIM = 3'd2;
   localparam logic [2:0] KW_HBT = 3'd3;
   localparam logic [2:0] KW_RESET = 3'd4;
   localparam logic [2:0] KW_STATUS = 3'd5;

   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      64'("SET_LED"), 64'("SET_ALL"), 64'("ANIM"), 64'("HBT"), 64'("RESET"), 64'("STATUS")
   };
   localparam int KW_LEN [NUM_KW] = '{7, 7, 4, 3, 5, 6};

   typedef struct packed {
      logic [7:0] data_byte;
      logic [31:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] event_kind;
      logic [2:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] anim_id;
      logic [31:0] drop_time;
      logic [63:0] line_head;
      logic [31:0] ok_count;
      logic [31:0] grammar_drops;
      logic [31:0] range_drops;
      logic [31:0] overflow_drops;
   } rsp_payload_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic eol;
      logic space;
      logic digit;
      logic idx_digit;
      logic [3:0] dval;
      logic [7:0] data;
      logic [31:0] time_ms;
   } q_item_type;

   // character p of keyword k, valid for p below the keyword length
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
      logic [63:0] t;
      t = KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - int'(p)));
      return t[7:0];
   endfunction

endpackage

// File: hw/rtl/lclp_front.sv
module lclp_front (
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lclp_pkg::req_payload_type req_payload,
   output logic                      q_valid,
   input  logic                      q_ready,
   output lclp_pkg::q_item_type      q_item
);

   logic [7:0] b;

   assign b = req_payload.data_byte;

   // cr is taken and dropped here
   assign req_ready = q_ready && !reset;
   assign q_valid = req_valid && (b != lclp_pkg::CHAR_CR);

   always_comb begin
      q_item.eol = (b == lclp_pkg::CHAR_LF);
      q_item.space = (b == lclp_pkg::CHAR_SPACE);
      q_item.digit = b inside {[lclp_pkg::CHAR_ZERO : lclp_pkg::CHAR_NINE]};
      q_item.idx_digit = b inside {[lclp_pkg::CHAR_ZERO : lclp_pkg::CHAR_FIVE]};
      q_item.dval = b[3:0];
      q_item.data = b;
      q_item.time_ms = req_payload.time_ms;
   end

endmodule

// File: hw/rtl/lclp_queue.sv
module lclp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lclp_pkg::q_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lclp_pkg::q_item_type out_item
);

   lclp_pkg::q_item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: hw/rtl/lclp_back.sv
module lclp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  lclp_pkg::q_item_type      q_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lclp_pkg::rsp_payload_type rsp_payload
);

   localparam logic [2:0] PS_KW = 3'd0;
   localparam logic [2:0] PS_SP = 3'd1;
   localparam logic [2:0] PS_IDX = 3'd2;
   localparam logic [2:0] PS_NUM0 = 3'd3;
   localparam logic [2:0] PS_NUM = 3'd4;
   localparam logic [2:0] PS_END = 3'd5;
   localparam logic [2:0] PS_FAIL = 3'd6;

   localparam int HW = $clog2(lclp_pkg::HEAD_BYTES);

   logic [lclp_pkg::LEN_W-1:0] len_ff, len_in;
   logic ovf_ff, ovf_in;
   logic [7:0] head_ff [lclp_pkg::HEAD_BYTES];
   logic [7:0] head_in [lclp_pkg::HEAD_BYTES];
   logic [2:0] ps_ff, ps_in;
   logic [lclp_pkg::NUM_KW-1:0] alive_ff, alive_in;
   logic [2:0] kpos_ff, kpos_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [1:0] fld_ff, fld_in;
   logic [7:0] acc_ff, acc_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic [7:0] anim_ff, anim_in;
   logic fail_range_ff, fail_range_in;
   logic [31:0] ok_cnt_ff, ok_cnt_in;
   logic [31:0] gram_cnt_ff, gram_cnt_in;
   logic [31:0] range_cnt_ff, range_cnt_in;
   logic [31:0] ovf_cnt_ff, ovf_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   lclp_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic q_fire;
   logic [63:0] head_bits;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign q_fire = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      head_bits = '0;
      for (int i = 0; i < lclp_pkg::HEAD_BYTES; i++) begin
         head_bits[8*i +: 8] = head_ff[i];
      end
   end

   always_comb begin
      logic emit;
      logic line_clr;
      logic [3:0] kind;
      logic more;
      logic st_en;
      logic [7:0] st_val;
      logic [lclp_pkg::NUM_KW-1:0] m;
      logic [11:0] prod;

      emit = 1'b0;
      line_clr = 1'b0;
      kind = lclp_pkg::EV_GRAMMAR;
      st_en = 1'b0;
      st_val = '0;
      m = '0;
      prod = '0;
      more = (cmd_ff != lclp_pkg::KW_ANIM) && (fld_ff != 2'd3);

      len_in = len_ff;
      ovf_in = ovf_ff;
      head_in = head_ff;
      ps_in = ps_ff;
      alive_in = alive_ff;
      kpos_in = kpos_ff;
      cmd_in = cmd_ff;
      fld_in = fld_ff;
      acc_in = acc_ff;
      idx_in = idx_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      anim_in = anim_ff;
      fail_range_in = fail_range_ff;
      ok_cnt_in = ok_cnt_ff;
      gram_cnt_in = gram_cnt_ff;
      range_cnt_in = range_cnt_ff;
      ovf_cnt_in = ovf_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      if (q_fire) begin
         if (q_item.eol) begin
            if (ovf_ff) begin
               ovf_in = 1'b0;
               line_clr = 1'b1;
            end else if (len_ff != '0) begin
               emit = 1'b1;
               line_clr = 1'b1;
               case (ps_ff)
                  PS_KW: begin
                     if (alive_ff[lclp_pkg::KW_HBT] && kpos_ff == 3'd3) begin
                        kind = lclp_pkg::EV_HBT;
                     end else if (alive_ff[lclp_pkg::KW_RESET] && kpos_ff == 3'd5) begin
                        kind = lclp_pkg::EV_RESET;
                     end else if (alive_ff[lclp_pkg::KW_STATUS] && kpos_ff == 3'd6) begin
                        kind = lclp_pkg::EV_STATUS;
                     end else begin
                        kind = lclp_pkg::EV_GRAMMAR;
                     end
                  end
                  PS_SP: kind = lclp_pkg::EV_GRAMMAR;
                  PS_IDX, PS_NUM0: kind = lclp_pkg::EV_RANGE;
                  PS_NUM: begin
                     // the last number ends at the line end
                     if (more) begin
                        kind = lclp_pkg::EV_GRAMMAR;
                     end else begin
                        kind = {1'b0, cmd_ff};
                        st_en = 1'b1;
                        st_val = acc_ff;
                     end
                  end
                  PS_END: kind = {1'b0, cmd_ff};
                  PS_FAIL: kind = fail_range_ff ? lclp_pkg::EV_RANGE : lclp_pkg::EV_GRAMMAR;
                  default: kind = lclp_pkg::EV_GRAMMAR;
               endcase
            end
         end else if (!ovf_ff) begin
            if (len_ff == lclp_pkg::LEN_W'(lclp_pkg::LINE_MAX)) begin
               emit = 1'b1;
               kind = lclp_pkg::EV_OVERFLOW;
               ovf_in = 1'b1;
            end else begin
               len_in = len_ff + 1'b1;
               if (len_ff < lclp_pkg::LEN_W'(lclp_pkg::HEAD_BYTES)) begin
                  head_in[len_ff[HW-1:0]] = q_item.data;
               end
               case (ps_ff)
                  PS_KW: begin
                     for (int i = 0; i < lclp_pkg::NUM_KW; i++) begin
                        m[i] = alive_ff[i] && (int'(kpos_ff) < lclp_pkg::KW_LEN[i]) &&
                               (q_item.data == lclp_pkg::kw_char(3'(i), kpos_ff));
                     end
                     alive_in = m;
                     kpos_in = kpos_ff + 3'd1;
                     if (m[lclp_pkg::KW_SET_LED] && kpos_ff == 3'd6) begin
                        ps_in = PS_SP;
                        cmd_in = lclp_pkg::KW_SET_LED;
                        fld_in = 2'd0;
                     end else if (m[lclp_pkg::KW_SET_ALL] && kpos_ff == 3'd6) begin
                        ps_in = PS_SP;
                        cmd_in = lclp_pkg::KW_SET_ALL;
                        fld_in = 2'd1;
                     end else if (m[lclp_pkg::KW_ANIM] && kpos_ff == 3'd3) begin
                        ps_in = PS_SP;
                        cmd_in = lclp_pkg::KW_ANIM;
                        fld_in = 2'd0;
                     end else if (m == '0) begin
                        ps_in = PS_FAIL;
                        fail_range_in = 1'b0;
                     end
                  end
                  PS_SP: begin
                     if (q_item.space) begin
                        ps_in = (cmd_ff == lclp_pkg::KW_SET_LED && fld_ff == 2'd0) ?
                                PS_IDX : PS_NUM0;
                     end else begin
                        ps_in = PS_FAIL;
                        fail_range_in = 1'b0;
                     end
                  end
                  PS_IDX: begin
                     if (q_item.idx_digit) begin
                        idx_in = q_item.dval[2:0];
                        fld_in = 2'd1;
                        ps_in = PS_SP;
                     end else begin
                        ps_in = PS_FAIL;
                        fail_range_in = 1'b1;
                     end
                  end
                  PS_NUM0: begin
                     if (!q_item.digit) begin
                        ps_in = PS_FAIL;
                        fail_range_in = 1'b1;
                     end else if (q_item.dval == 4'd0) begin
                        // a lone zero closes the number at once
                        st_en = 1'b1;
                        st_val = '0;
                        if (more) begin
                           fld_in = fld_ff + 2'd1;
                           ps_in = PS_SP;
                        end else begin
                           ps_in = PS_END;
                        end
                     end else begin
                        acc_in = {4'd0, q_item.dval};
                        ps_in = PS_NUM;
                     end
                  end
                  PS_NUM: begin
                     if (q_item.digit) begin
                        prod = {acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {8'd0, q_item.dval};
                        if (prod > {3'b000, lclp_pkg::BYTE_MAX}) begin
                           ps_in = PS_FAIL;
                           fail_range_in = 1'b1;
                        end else begin
                           acc_in = prod[7:0];
                        end
                     end else begin
                        st_en = 1'b1;
                        st_val = acc_ff;
                        if (more && q_item.space) begin
                           fld_in = fld_ff + 2'd1;
                           ps_in = PS_NUM0;
                        end else begin
                           ps_in = PS_FAIL;
                           fail_range_in = 1'b0;
                        end
                     end
                  end
                  PS_END: begin
                     ps_in = PS_FAIL;
                     fail_range_in = 1'b0;
                  end
                  PS_FAIL: ps_in = PS_FAIL;
                  default: begin
                     ps_in = PS_FAIL;
                     fail_range_in = 1'b0;
                  end
               endcase
            end
         end
      end

      if (st_en) begin
         case (fld_ff)
            2'd0: anim_in = st_val;
            2'd1: red_in = st_val;
            2'd2: green_in = st_val;
            2'd3: blue_in = st_val;
            default: anim_in = st_val;
         endcase
      end

      if (emit) begin
         case (kind)
            lclp_pkg::EV_OVERFLOW: ovf_cnt_in = ovf_cnt_ff + 32'd1;
            lclp_pkg::EV_RANGE: range_cnt_in = range_cnt_ff + 32'd1;
            lclp_pkg::EV_GRAMMAR: gram_cnt_in = gram_cnt_ff + 32'd1;
            default: ok_cnt_in = ok_cnt_ff + 32'd1;
         endcase
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.event_kind = kind;
         if (kind == lclp_pkg::EV_SET_LED) begin
            rsp_in.led_index = idx_ff;
         end
         if (kind == lclp_pkg::EV_SET_LED || kind == lclp_pkg::EV_SET_ALL) begin
            rsp_in.red = red_in;
            rsp_in.green = green_in;
            rsp_in.blue = blue_in;
         end
         if (kind == lclp_pkg::EV_ANIM) begin
            rsp_in.anim_id = anim_in;
         end
         if (kind == lclp_pkg::EV_GRAMMAR || kind == lclp_pkg::EV_RANGE ||
             kind == lclp_pkg::EV_OVERFLOW) begin
            rsp_in.drop_time = q_item.time_ms;
            rsp_in.line_head = head_bits;
         end
         rsp_in.ok_count = ok_cnt_in;
         rsp_in.grammar_drops = gram_cnt_in;
         rsp_in.range_drops = range_cnt_in;
         rsp_in.overflow_drops = ovf_cnt_in;
      end

      if (line_clr) begin
         len_in = '0;
         for (int i = 0; i < lclp_pkg::HEAD_BYTES; i++) begin
            head_in[i] = '0;
         end
         ps_in = PS_KW;
         alive_in = '1;
         kpos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
         for (int i = 0; i < lclp_pkg::HEAD_BYTES; i++) begin
            head_ff[i] <= '0;
         end
         ps_ff <= PS_KW;
         alive_ff <= '1;
         kpos_ff <= '0;
         ok_cnt_ff <= '0;
         gram_cnt_ff <= '0;
         range_cnt_ff <= '0;
         ovf_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         head_ff <= head_in;
         ps_ff <= ps_in;
         alive_ff <= alive_in;
         kpos_ff <= kpos_in;
         ok_cnt_ff <= ok_cnt_in;
         gram_cnt_ff <= gram_cnt_in;
         range_cnt_ff <= range_cnt_in;
         ovf_cnt_ff <= ovf_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      fld_ff <= fld_in;
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
      anim_ff <= anim_in;
      fail_range_ff <= fail_range_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: hw/rtl/led_command_line_parser.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_payload (data_byte, time_ms)
// rsp       out        rsp_valid/rsp_ready  rsp_payload (event, values, drop info, counters)
//
// one byte per cycle sustained while no waiting result holds the back; the parser
// advances one byte per step, so the line is parsed as it arrives and lf resolves in the step that takes it
// rsp_valid rises after its byte passes the queue stage, then the output register
// a waiting result holds the back; the two-entry queue fills, then
// req_ready drops until the result transfer
// reset is synchronous; counters, line state and both valids clear
module led_command_line_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lclp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lclp_pkg::rsp_payload_type rsp_payload
);

   logic fq_valid, fq_ready;
   lclp_pkg::q_item_type fq_item;
   logic qb_valid, qb_ready;
   lclp_pkg::q_item_type qb_item;

   lclp_front u_front (
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (fq_valid),
      .q_ready     (fq_ready),
      .q_item      (fq_item)
   );

   lclp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   lclp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (qb_valid),
      .q_ready     (qb_ready),
      .q_item      (qb_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
